### sv/hlpab_pkg.sv
// Shared types and constants for the length-prefixed to Annex B converter.
// Used by the front end, the command queue, the back end and the top level.
package hlpab_pkg;

  localparam int unsigned HoldDepth = 23;
  localparam int unsigned CfgHeader = 22;
  localparam int unsigned HoldIdxW  = $clog2(HoldDepth);

  localparam logic [1:0] StatusConverted = 2'd0;
  localparam logic [1:0] StatusPassed    = 2'd1;
  localparam logic [1:0] StatusBadLength = 2'd2;
  localparam logic [1:0] StatusBadConfig = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_out;
    logic [1:0] status;
  } out_item_t;

  // What the back end has to do for one input byte.
  typedef enum logic [1:0] {
    CMD_NOP,    // no data; a bare end marker if last is set
    CMD_BYTE,   // emit data
    CMD_START,  // emit 00 00 00 01
    CMD_FLUSH   // emit held bytes 0 .. cnt-1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [7:0]          data;
    logic                wr_en;   // store data into the hold buffer at wr_idx
    logic [HoldIdxW-1:0] wr_idx;
    logic [HoldIdxW-1:0] cnt;
    logic                last;
    logic [1:0]          status;
  } cmd_t;

endpackage

### sv/hlpab_front.sv
// Front end: parses the incoming buffer byte by byte and issues one command
// per byte that has any effect. Depends on hlpab_pkg.
module hlpab_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hlpab_pkg::in_item_t in_item_i,
  input  logic               cmd_ready_i,
  output logic               cmd_valid_o,
  output hlpab_pkg::cmd_t    cmd_o
);
  import hlpab_pkg::*;

  localparam logic [3:0] PhClassify = 4'd0;
  localparam logic [3:0] PhPass     = 4'd1;
  localparam logic [3:0] PhLenHdr   = 4'd2;
  localparam logic [3:0] PhLenPay   = 4'd3;
  localparam logic [3:0] PhCfgArr   = 4'd4;
  localparam logic [3:0] PhCfgNumHi = 4'd5;
  localparam logic [3:0] PhCfgNumLo = 4'd6;
  localparam logic [3:0] PhCfgLenHi = 4'd7;
  localparam logic [3:0] PhCfgLenLo = 4'd8;
  localparam logic [3:0] PhCfgPay   = 4'd9;
  localparam logic [3:0] PhLenBad   = 4'd10;
  localparam logic [3:0] PhCfgDone  = 4'd11;

  localparam logic [HoldIdxW-1:0] IdxLast   = HoldIdxW'(CfgHeader);
  localparam logic [HoldIdxW-1:0] IdxFull   = HoldIdxW'(HoldDepth);
  localparam logic [HoldIdxW-1:0] IdxDecide = HoldIdxW'(3);

  logic [3:0]          ph_q, ph_d;
  logic [HoldIdxW-1:0] cnt_q, cnt_d;
  logic [7:0]          h0_q, h0_d, h1_q, h1_d, h2_q, h2_d, h22_q, h22_d;
  logic [7:0]          arr_q, arr_d;
  logic [15:0]         nal_q, nal_d;
  logic [23:0]         acc_q, acc_d;
  logic [31:0]         pay_q, pay_d;
  logic                units_q, units_d;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic [7:0]  first;
  logic        annexb;
  logic        do_len;
  logic [31:0] len_val;
  logic [15:0] nal_lo;
  logic [1:0]  status;
  cmd_t        cmd;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && cmd_ready_i;
  assign b          = in_item_i.data_byte;
  assign last       = in_item_i.last_in;
  assign first      = (cnt_q == '0) ? b : h0_q;
  assign annexb     = (h0_q == 8'h00) && (h1_q == 8'h00) &&
                      ((h2_q == 8'h01) || ((h2_q == 8'h00) && (b == 8'h01)));
  assign nal_lo     = {nal_q[15:8], b};

  always_comb begin
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    h0_d    = h0_q;
    h1_d    = h1_q;
    h2_d    = h2_q;
    h22_d   = h22_q;
    arr_d   = arr_q;
    nal_d   = nal_q;
    acc_d   = acc_q;
    pay_d   = pay_q;
    units_d = units_q;
    do_len  = 1'b0;
    len_val = {acc_q, b};
    status  = StatusConverted;
    cmd.kind   = CMD_NOP;
    cmd.data   = b;
    cmd.wr_en  = 1'b0;
    cmd.wr_idx = cnt_q;
    cmd.cnt    = '0;
    cmd.last   = last;
    cmd.status = StatusConverted;

    unique case (ph_q)
      PhClassify: begin
        if ((first != 8'h01) && (cnt_q == IdxDecide)) begin
          if (annexb) begin
            cmd.kind   = CMD_FLUSH;
            cmd.wr_en  = 1'b1;
            cmd.cnt    = IdxDecide + HoldIdxW'(1);
            ph_d       = PhPass;
          end else begin
            do_len  = 1'b1;
            len_val = {h0_q, h1_q, h2_q, b};
          end
        end else if ((first == 8'h01) && (cnt_q >= IdxFull)) begin
          // Record header is complete; this byte is the first array header byte.
          arr_d   = h22_q;
          units_d = 1'b0;
          ph_d    = (h22_q == 8'h00) ? PhCfgDone : PhCfgNumHi;
        end else begin
          cmd.wr_en = 1'b1;
          cnt_d     = cnt_q + HoldIdxW'(1);
          if (cnt_q == '0) h0_d = b;
          if (cnt_q == HoldIdxW'(1)) h1_d = b;
          if (cnt_q == HoldIdxW'(2)) h2_d = b;
          if (cnt_q == IdxLast) h22_d = b;
          if (last) begin
            cmd.kind = CMD_FLUSH;
            cmd.cnt  = cnt_q + HoldIdxW'(1);
            ph_d     = PhPass;
          end
        end
      end
      PhPass: begin
        cmd.kind = CMD_BYTE;
      end
      PhLenHdr: begin
        acc_d = {acc_q[15:0], b};
        cnt_d = cnt_q + HoldIdxW'(1);
        if (cnt_q == IdxDecide) do_len = 1'b1;
      end
      PhLenPay: begin
        cmd.kind = CMD_BYTE;
        pay_d    = pay_q - 32'd1;
        if (pay_q == 32'd1) begin
          ph_d  = PhLenHdr;
          cnt_d = '0;
          acc_d = '0;
        end
      end
      PhCfgArr: begin
        ph_d = PhCfgNumHi;
      end
      PhCfgNumHi: begin
        nal_d = {b, 8'h00};
        ph_d  = PhCfgNumLo;
      end
      PhCfgNumLo: begin
        nal_d = nal_lo;
        if (nal_lo == 16'd0) begin
          arr_d = arr_q - 8'd1;
          ph_d  = (arr_q == 8'd1) ? PhCfgDone : PhCfgArr;
        end else begin
          ph_d = PhCfgLenHi;
        end
      end
      PhCfgLenHi: begin
        pay_d = {16'd0, b, 8'h00};
        ph_d  = PhCfgLenLo;
      end
      PhCfgLenLo: begin
        pay_d    = {pay_q[31:8], b};
        units_d  = 1'b1;
        cmd.kind = CMD_START;
        if ({pay_q[31:8], b} == 32'd0) begin
          nal_d = nal_q - 16'd1;
          if (nal_q == 16'd1) begin
            arr_d = arr_q - 8'd1;
            ph_d  = (arr_q == 8'd1) ? PhCfgDone : PhCfgArr;
          end else begin
            ph_d = PhCfgLenHi;
          end
        end else begin
          ph_d = PhCfgPay;
        end
      end
      PhCfgPay: begin
        cmd.kind = CMD_BYTE;
        pay_d    = pay_q - 32'd1;
        if (pay_q == 32'd1) begin
          nal_d = nal_q - 16'd1;
          if (nal_q == 16'd1) begin
            arr_d = arr_q - 8'd1;
            ph_d  = (arr_q == 8'd1) ? PhCfgDone : PhCfgArr;
          end else begin
            ph_d = PhCfgLenHi;
          end
        end
      end
      default: begin
      end
    endcase

    // A new length word is complete: a zero length kills the rest of the buffer.
    if (do_len) begin
      cnt_d = '0;
      acc_d = '0;
      if (len_val == 32'd0) begin
        ph_d = PhLenBad;
      end else begin
        units_d  = 1'b1;
        pay_d    = len_val;
        ph_d     = PhLenPay;
        cmd.kind = CMD_START;
      end
    end

    priority if (ph_d == PhPass) begin
      status = StatusPassed;
    end else if (ph_d == PhLenHdr) begin
      status = ((cnt_d == '0) && units_d) ? StatusConverted : StatusBadLength;
    end else if (ph_d == PhCfgDone) begin
      status = units_d ? StatusConverted : StatusBadConfig;
    end else if ((ph_d >= PhCfgArr) && (ph_d <= PhCfgPay)) begin
      status = StatusBadConfig;
    end else begin
      status = StatusBadLength;
    end
    cmd.status = last ? status : StatusConverted;

    if (last) begin
      ph_d    = PhClassify;
      cnt_d   = '0;
      arr_d   = '0;
      nal_d   = '0;
      acc_d   = '0;
      pay_d   = '0;
      units_d = 1'b0;
    end
  end

  assign cmd_valid_o = accept && ((cmd.kind != CMD_NOP) || cmd.wr_en || last);
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PhClassify;
      cnt_q   <= '0;
      arr_q   <= '0;
      nal_q   <= '0;
      acc_q   <= '0;
      pay_q   <= '0;
      units_q <= 1'b0;
    end else if (accept) begin
      ph_q    <= ph_d;
      cnt_q   <= cnt_d;
      arr_q   <= arr_d;
      nal_q   <= nal_d;
      acc_q   <= acc_d;
      pay_q   <= pay_d;
      units_q <= units_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      h0_q  <= h0_d;
      h1_q  <= h1_d;
      h2_q  <= h2_d;
      h22_q <= h22_d;
    end
  end

endmodule

### sv/hlpab_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on hlpab_pkg for the command type.
module hlpab_cmd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            ready_o,
  input  hlpab_pkg::cmd_t push_cmd_i,
  input  logic            pop_i,
  output logic            valid_o,
  output hlpab_pkg::cmd_t head_o
);
  import hlpab_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign ready_o = (count_q != CntFull);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (!do_push && do_pop) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

### sv/hlpab_back.sv
// Back end: expands queued commands into output bytes, owns the hold buffer
// and the output register. Depends on hlpab_pkg.
module hlpab_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_pop_o,
  input  hlpab_pkg::cmd_t      cmd_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hlpab_pkg::out_item_t out_item_o
);
  import hlpab_pkg::*;

  localparam logic [HoldIdxW-1:0] PosStartEnd = HoldIdxW'(3);

  logic [7:0]          hold_q [HoldDepth];
  cmd_t                cur_q;
  logic                cur_valid_q;
  logic [HoldIdxW-1:0] pos_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic      step, emit, final_step, consume, load, pop;
  out_item_t item;

  always_comb begin
    emit            = 1'b1;
    final_step      = 1'b1;
    item.out_byte   = cur_q.data;
    item.byte_valid = 1'b1;
    unique case (cur_q.kind)
      CMD_NOP: begin
        emit            = cur_q.last;
        item.out_byte   = 8'h00;
        item.byte_valid = 1'b0;
      end
      CMD_BYTE: begin
      end
      CMD_START: begin
        final_step    = (pos_q == PosStartEnd);
        item.out_byte = (pos_q == PosStartEnd) ? 8'h01 : 8'h00;
      end
      CMD_FLUSH: begin
        final_step = ((pos_q + HoldIdxW'(1)) == cur_q.cnt);
      end
      default: begin
      end
    endcase
    item.last_out = cur_q.last && final_step;
    item.status   = item.last_out ? cur_q.status : StatusConverted;
  end

  // The next command is taken in the same cycle the current one finishes.
  assign step      = cur_valid_q && (!out_valid_q || out_ready_i);
  assign consume   = step && final_step;
  assign load      = !cur_valid_q || consume;
  assign pop       = load && cmd_valid_i;
  assign cmd_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= cmd_valid_i;
        pos_q       <= '0;
      end else if (step) begin
        pos_q <= pos_q + HoldIdxW'(1);
      end
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= step && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= cmd_i;
      if (cmd_i.wr_en) hold_q[cmd_i.wr_idx] <= cmd_i.data;
    end
    if (step && emit) begin
      out_q.byte_valid <= item.byte_valid;
      out_q.last_out   <= item.last_out;
      out_q.status     <= item.status;
      // Held bytes go straight from the buffer into the output register.
      out_q.out_byte   <= (cur_q.kind == CMD_FLUSH) ? hold_q[pos_q] : item.out_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### sv/hevc_length_prefix_to_annexb_core.sv
// Converts one HEVC packet buffer, fed one byte per cycle with a mark on its
// final byte, into Annex B form: length prefixes (4-byte in a length stream,
// 2-byte inside a leading configuration record) become 00 00 00 01 start codes,
// Annex B and short buffers pass through, and the last result of each buffer
// carries a status. Input is taken at one byte per cycle while the output side
// keeps up; each start code expands to four output bytes, and a buffer that is
// held for classification (up to 23 bytes) is replayed at one byte per cycle,
// all paced by the single output register of the back end, with a command
// queue of CmdFifoDepth entries absorbing the bursts. No clearing pass is
// needed after reset.
module hevc_length_prefix_to_annexb_core #(
  parameter int unsigned CmdFifoDepth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hlpab_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hlpab_pkg::out_item_t out_item_o
);
  import hlpab_pkg::*;

  logic cmd_push, cmd_ready, cmd_valid, cmd_pop;
  cmd_t cmd_in, cmd_head;

  hlpab_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_ready_i (cmd_ready),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_in)
  );

  hlpab_cmd_fifo #(
    .Depth (CmdFifoDepth)
  ) u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .ready_o    (cmd_ready),
    .push_cmd_i (cmd_in),
    .pop_i      (cmd_pop),
    .valid_o    (cmd_valid),
    .head_o     (cmd_head)
  );

  hlpab_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd_head),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
